[hw/rtl/hsv_pkg.sv]
// Shared types, constants and arithmetic helpers of the HSV to RGB converter.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package hsv_pkg;

   localparam logic [11:0] SectorSpan = 12'd600;
   localparam logic [11:0] HueLimit   = 12'd3600;
   localparam logic [9:0]  FullScale  = 10'd1000;
   localparam logic [7:0]  ChannelMax = 8'd255;

   // floor(x / 1000) is estimated as (x * 1048) >> 20, which is never high
   // and at most one low for x up to a million.
   localparam logic [10:0] Div1kRecip = 11'd1048;
   // floor(rem * 5 / 3) equals (rem * 13655) >> 13 for rem below 600.
   localparam logic [13:0] FracRecip  = 14'd13655;

   typedef enum logic [2:0] {
      SEC_R_TO_Y = 3'd0,
      SEC_Y_TO_G = 3'd1,
      SEC_G_TO_C = 3'd2,
      SEC_C_TO_B = 3'd3,
      SEC_B_TO_M = 3'd4,
      SEC_M_TO_R = 3'd5
   } sector_type;

   typedef struct packed {
      logic [11:0] hue_tenths;
      logic [9:0]  saturation;
      logic [9:0]  brightness;
   } req_type;

   typedef struct packed {
      logic [7:0] red_out;
      logic [7:0] green_out;
      logic [7:0] blue_out;
   } rsp_type;

   // A classified request as it waits between the front and the back end.
   typedef struct packed {
      logic       black;
      sector_type sector;
      logic [9:0] rem;
      logic [9:0] sat;
      logic [9:0] val;
   } work_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

   function automatic logic [9:0] frac_of(input logic [9:0] rem);
      logic [23:0] prod;
      prod = {14'd0, rem} * {10'd0, FracRecip};
      return prod[22:13];
   endfunction

   function automatic logic [9:0] div1k_est(input logic [19:0] x);
      logic [30:0] prod;
      prod = {11'd0, x} * {20'd0, Div1kRecip};
      return prod[29:20];
   endfunction

   function automatic logic [9:0] div1k_fix(input logic [19:0] x, input logic [9:0] est);
      logic [19:0] left;
      left = x - ({10'd0, est} * {10'd0, FullScale});
      return (left >= {10'd0, FullScale}) ? est + 10'd1 : est;
   endfunction

endpackage

[hw/rtl/hsv_to_rgb_converter_core.sv]
// Top level of the HSV to RGB converter: front end, work queue, pipelined back
// end and result queue. Depends on hsv_pkg, hsv_front, hsv_fifo and hsv_back.
//
//   Channel   Direction   Handshake                 Payload
//   req       in          req_push / req_full       req_data  (hue, saturation, value)
//   rsp       out         rsp_pop / rsp_empty       rsp_data  (red, green, blue)
//
// One request is taken per clock and one result delivered per clock, sustained
// while rsp_pop stays high. A request passes the front register, the work queue,
// ten back-end stages and the result queue on its way to a result.
// Reset is synchronous and empties both queues and all stage valid bits.
// While rsp_pop stays low the back end holds once the result queue is full;
// the front keeps taking requests until the work queue fills, then raises req_full.
`timescale 1ns / 1ps

module hsv_to_rgb_converter_core #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  hsv_pkg::req_type req_data,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output hsv_pkg::rsp_type rsp_data
);
   import hsv_pkg::*;

   localparam int WorkW = $bits(work_type);
   localparam int RspW  = $bits(rsp_type);

   q_stat_type       mid_stat, out_stat;
   logic             mid_push, mid_pop, back_push;
   work_type         front_data, mid_data;
   logic [WorkW-1:0] mid_raw;
   rsp_type          back_data;
   logic [RspW-1:0]  out_raw;

   hsv_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .mid_stat (mid_stat),
      .mid_push (mid_push),
      .mid_data (front_data)
   );

   hsv_fifo #(
      .WIDTH (WorkW),
      .DEPTH (QUEUE_DEPTH)
   ) u_work_q (
      .clock     (clock),
      .reset     (reset),
      .push      (mid_push),
      .push_data (front_data),
      .pop       (mid_pop),
      .pop_data  (mid_raw),
      .stat      (mid_stat)
   );

   assign mid_data = work_type'(mid_raw);

   hsv_back u_back (
      .clock    (clock),
      .reset    (reset),
      .in_stat  (mid_stat),
      .in_data  (mid_data),
      .in_pop   (mid_pop),
      .out_stat (out_stat),
      .out_push (back_push),
      .out_data (back_data)
   );

   hsv_fifo #(
      .WIDTH (RspW),
      .DEPTH (QUEUE_DEPTH)
   ) u_rsp_q (
      .clock     (clock),
      .reset     (reset),
      .push      (back_push),
      .push_data (back_data),
      .pop       (rsp_pop),
      .pop_data  (out_raw),
      .stat      (out_stat)
   );

   assign rsp_empty = out_stat.empty;
   assign rsp_data  = rsp_type'(out_raw);

`ifndef SYNTHESIS
   // The back end must never push into a full result queue.
   a_rsp_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(back_push && out_stat.full))
      else $error("result queue overflow");

   // A staged request that meets a full work queue stays put until it goes in.
   a_work_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (mid_push && mid_stat.full) |=> (mid_push && $stable(front_data)))
      else $error("staged request changed while the work queue was full");

   // An accepted request is staged for the work queue on the next cycle.
   a_req_staged: assert property (@(posedge clock) disable iff (reset)
      (req_push && !req_full) |=> mid_push)
      else $error("accepted request was not staged");

   // The back end only pops the work queue when it has an entry.
   a_work_no_underflow: assert property (@(posedge clock) disable iff (reset)
      mid_pop |-> !mid_stat.empty)
      else $error("work queue popped while empty");
`endif

endmodule

[hw/rtl/hsv_fifo.sv]
// Small register-based queue used between the converter's stages.
// Depends on hsv_pkg for the status struct.
`timescale 1ns / 1ps

module hsv_fifo #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  logic [WIDTH-1:0]     push_data,
   input  logic                 pop,
   output logic [WIDTH-1:0]     pop_data,
   output hsv_pkg::q_stat_type  stat
);
   import hsv_pkg::*;

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic             do_push, do_pop;

   assign stat.full  = (count_ff == CntW'(DEPTH));
   assign stat.empty = (count_ff == '0);
   assign do_push    = push && !stat.full;
   assign do_pop     = pop && !stat.empty;
   assign pop_data   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[hw/rtl/hsv_front.sv]
// Front end: takes requests, clamps saturation and value, finds the hue sector.
// Depends on hsv_pkg; feeds the work queue in front of hsv_back.
`timescale 1ns / 1ps

module hsv_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   output logic                req_full,
   input  hsv_pkg::req_type    req_data,
   input  hsv_pkg::q_stat_type mid_stat,
   output logic                mid_push,
   output hsv_pkg::work_type   mid_data
);
   import hsv_pkg::*;

   logic       valid_ff;
   work_type   work_ff, work_in;
   logic [11:0] base;
   logic        accept;

   // The staged request can leave only when the work queue has room.
   assign req_full = valid_ff && mid_stat.full;
   assign accept   = req_push && !req_full;
   assign mid_push = valid_ff;
   assign mid_data = work_ff;

   always_comb begin
      work_in.black = (req_data.hue_tenths >= HueLimit);
      if (req_data.hue_tenths < SectorSpan) begin
         work_in.sector = SEC_R_TO_Y;
         base = 12'd0;
      end else if (req_data.hue_tenths < 12'(2 * SectorSpan)) begin
         work_in.sector = SEC_Y_TO_G;
         base = SectorSpan;
      end else if (req_data.hue_tenths < 12'(3 * SectorSpan)) begin
         work_in.sector = SEC_G_TO_C;
         base = 12'(2 * SectorSpan);
      end else if (req_data.hue_tenths < 12'(4 * SectorSpan)) begin
         work_in.sector = SEC_C_TO_B;
         base = 12'(3 * SectorSpan);
      end else if (req_data.hue_tenths < 12'(5 * SectorSpan)) begin
         work_in.sector = SEC_B_TO_M;
         base = 12'(4 * SectorSpan);
      end else begin
         work_in.sector = SEC_M_TO_R;
         base = 12'(5 * SectorSpan);
      end
      // Out-of-range hues come out black, so their offset is simply zeroed.
      work_in.rem = work_in.black ? 10'd0 : 10'(req_data.hue_tenths - base);
      work_in.sat = (req_data.saturation > FullScale) ? FullScale : req_data.saturation;
      work_in.val = (req_data.brightness > FullScale) ? FullScale : req_data.brightness;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!req_full) begin
         valid_ff <= req_push;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         work_ff <= work_in;
      end
   end

endmodule

[hw/rtl/hsv_back.sv]
// Back end: ten-stage pipeline that forms p, q and t, maps them to the channels
// and scales them to 8 bits. Depends on hsv_pkg for types and helpers.
`timescale 1ns / 1ps

module hsv_back (
   input  logic                clock,
   input  logic                reset,
   input  hsv_pkg::q_stat_type in_stat,
   input  hsv_pkg::work_type   in_data,
   output logic                in_pop,
   input  hsv_pkg::q_stat_type out_stat,
   output logic                out_push,
   output hsv_pkg::rsp_type    out_data
);
   import hsv_pkg::*;

   localparam int Stages = 10;

   logic              en;
   logic [Stages-1:0] vld_ff;
   sector_type        sec_ff [6];
   logic              blk_ff [9];

   // Stage 1: fraction and p numerator.
   logic [9:0]  f1_ff, f1_in, s1_ff, v1_ff;
   logic [19:0] pn1_ff, pn1_in;
   // Stage 2: s*f and s*(1000-f), estimate of p.
   logic [19:0] sf2_ff, sf2_in, st2_ff, st2_in, pn2_ff;
   logic [9:0]  pe2_ff, pe2_in, v2_ff;
   // Stage 3: quotient estimates, p finished.
   logic [19:0] sf3_ff, st3_ff;
   logic [9:0]  sfe3_ff, sfe3_in, ste3_ff, ste3_in, p3_ff, p3_in, v3_ff;
   // Stage 4: finished s*f/1000 and s*(1000-f)/1000.
   logic [9:0]  a4_ff, a4_in, b4_ff, b4_in, p4_ff, v4_ff;
   // Stage 5: q and t numerators.
   logic [19:0] qn5_ff, qn5_in, tn5_ff, tn5_in;
   logic [9:0]  p5_ff, v5_ff;
   // Stage 6: q and t estimates.
   logic [19:0] qn6_ff, tn6_ff;
   logic [9:0]  qe6_ff, qe6_in, te6_ff, te6_in, p6_ff, v6_ff;
   // Stages 7 to 10: per channel, red, green, blue.
   logic [9:0]  x7_ff [3], x7_in [3];
   logic [9:0]  q7, t7;
   logic [17:0] n8_ff [3], n8_in [3];
   logic [17:0] n9_ff [3];
   logic [9:0]  e9_ff [3], e9_in [3];
   logic [7:0]  c10_ff [3], c10_in [3];
   logic [9:0]  full10 [3];

   // The whole pipeline moves together; it holds while the result queue is full.
   assign en       = !out_stat.full;
   assign in_pop   = en && !in_stat.empty;
   assign out_push = en && vld_ff[Stages-1];
   assign out_data = '{red_out: c10_ff[0], green_out: c10_ff[1], blue_out: c10_ff[2]};

   always_comb begin
      f1_in   = frac_of(in_data.rem);
      pn1_in  = {10'd0, in_data.val} * {10'd0, FullScale - in_data.sat};
      sf2_in  = {10'd0, s1_ff} * {10'd0, f1_ff};
      st2_in  = {10'd0, s1_ff} * {10'd0, FullScale - f1_ff};
      pe2_in  = div1k_est(pn1_ff);
      sfe3_in = div1k_est(sf2_ff);
      ste3_in = div1k_est(st2_ff);
      p3_in   = div1k_fix(pn2_ff, pe2_ff);
      a4_in   = div1k_fix(sf3_ff, sfe3_ff);
      b4_in   = div1k_fix(st3_ff, ste3_ff);
      qn5_in  = {10'd0, v4_ff} * {10'd0, FullScale - a4_ff};
      tn5_in  = {10'd0, v4_ff} * {10'd0, FullScale - b4_ff};
      qe6_in  = div1k_est(qn5_ff);
      te6_in  = div1k_est(tn5_ff);
      q7      = div1k_fix(qn6_ff, qe6_ff);
      t7      = div1k_fix(tn6_ff, te6_ff);
      case (sec_ff[5])
         SEC_R_TO_Y: begin x7_in[0] = v6_ff; x7_in[1] = t7;    x7_in[2] = p6_ff; end
         SEC_Y_TO_G: begin x7_in[0] = q7;    x7_in[1] = v6_ff; x7_in[2] = p6_ff; end
         SEC_G_TO_C: begin x7_in[0] = p6_ff; x7_in[1] = v6_ff; x7_in[2] = t7;    end
         SEC_C_TO_B: begin x7_in[0] = p6_ff; x7_in[1] = q7;    x7_in[2] = v6_ff; end
         SEC_B_TO_M: begin x7_in[0] = t7;    x7_in[1] = p6_ff; x7_in[2] = v6_ff; end
         SEC_M_TO_R: begin x7_in[0] = v6_ff; x7_in[1] = p6_ff; x7_in[2] = q7;    end
         default:    begin x7_in[0] = v6_ff; x7_in[1] = p6_ff; x7_in[2] = q7;    end
      endcase
      for (int c = 0; c < 3; c++) begin
         n8_in[c]  = {8'd0, x7_ff[c]} * {10'd0, ChannelMax};
         e9_in[c]  = div1k_est({2'd0, n8_ff[c]});
         full10[c] = div1k_fix({2'd0, n9_ff[c]}, e9_ff[c]);
         c10_in[c] = blk_ff[8] ? 8'd0 : full10[c][7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[Stages-2:0], !in_stat.empty};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sec_ff[0] <= in_data.sector;
         for (int k = 1; k < 6; k++) begin
            sec_ff[k] <= sec_ff[k-1];
         end
         blk_ff[0] <= in_data.black;
         for (int k = 1; k < 9; k++) begin
            blk_ff[k] <= blk_ff[k-1];
         end
         f1_ff   <= f1_in;
         pn1_ff  <= pn1_in;
         s1_ff   <= in_data.sat;
         v1_ff   <= in_data.val;
         sf2_ff  <= sf2_in;
         st2_ff  <= st2_in;
         pn2_ff  <= pn1_ff;
         pe2_ff  <= pe2_in;
         v2_ff   <= v1_ff;
         sf3_ff  <= sf2_ff;
         st3_ff  <= st2_ff;
         sfe3_ff <= sfe3_in;
         ste3_ff <= ste3_in;
         p3_ff   <= p3_in;
         v3_ff   <= v2_ff;
         a4_ff   <= a4_in;
         b4_ff   <= b4_in;
         p4_ff   <= p3_ff;
         v4_ff   <= v3_ff;
         qn5_ff  <= qn5_in;
         tn5_ff  <= tn5_in;
         p5_ff   <= p4_ff;
         v5_ff   <= v4_ff;
         qn6_ff  <= qn5_ff;
         tn6_ff  <= tn5_ff;
         qe6_ff  <= qe6_in;
         te6_ff  <= te6_in;
         p6_ff   <= p5_ff;
         v6_ff   <= v5_ff;
         for (int c = 0; c < 3; c++) begin
            x7_ff[c]  <= x7_in[c];
            n8_ff[c]  <= n8_in[c];
            n9_ff[c]  <= n8_ff[c];
            e9_ff[c]  <= e9_in[c];
            c10_ff[c] <= c10_in[c];
         end
      end
   end

endmodule

[test/tb_top.sv]
// Self-checking testbench for hsv_to_rgb_converter_core: HSV requests in, RGB results out.
// Depends on hsv_pkg for the payload types, the sector names and the scale constants.
`timescale 1ns / 1ps

module tb_top;
   import hsv_pkg::*;

   localparam int WatchdogLimit = 4000;
   localparam int HoldCycles    = 150;
   localparam int RandomCount   = 1550;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_push  = 1'b0;
   logic    req_full;
   req_type req_data  = '0;
   logic    rsp_empty;
   logic    rsp_pop   = 1'b0;
   rsp_type rsp_data;

   req_type pending_hsv[$];
   rsp_type expected_rgb[$];

   int error_count  = 0;
   int rgb_checked  = 0;
   int send_wait    = 0;
   int send_calm    = 0;
   int recv_wait    = 0;
   int recv_calm    = 0;
   int idle_cycles  = 0;
   int hold_count   = 0;
   int next_hold_at = 300;
   bit rsp_hold     = 1'b0;

   hsv_to_rgb_converter_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .rsp_empty(rsp_empty),
      .rsp_pop  (rsp_pop),
      .rsp_data (rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Integer HSV to RGB with truncating division at every step.
   function automatic rsp_type predict_rgb(input req_type px);
      int unsigned span, full, cmax;
      int unsigned hue, sat, val, f, p, q, t, r, g, b;
      rsp_type rgb;
      span = SectorSpan;
      full = FullScale;
      cmax = ChannelMax;
      hue = px.hue_tenths;
      sat = (px.saturation > full) ? full : px.saturation;
      val = (px.brightness > full) ? full : px.brightness;
      rgb = '0;
      if (hue >= int'(HueLimit)) return rgb;
      f = ((hue % span) * full) / span;
      p = (val * (full - sat)) / full;
      q = (val * (full - (sat * f) / full)) / full;
      t = (val * (full - (sat * (full - f)) / full)) / full;
      case (sector_type'(hue / span))
         SEC_R_TO_Y: begin r = val; g = t;   b = p;   end
         SEC_Y_TO_G: begin r = q;   g = val; b = p;   end
         SEC_G_TO_C: begin r = p;   g = val; b = t;   end
         SEC_C_TO_B: begin r = p;   g = q;   b = val; end
         SEC_B_TO_M: begin r = t;   g = p;   b = val; end
         default: begin r = val; g = p; b = q; end
      endcase
      rgb.red_out   = 8'((cmax * r) / full);
      rgb.green_out = 8'((cmax * g) / full);
      rgb.blue_out  = 8'((cmax * b) / full);
      return rgb;
   endfunction

   // Mostly short waits, now and then a long one, and none at all while calm.
   function automatic int draw_wait(input bit calm);
      if (calm) return 0;
      return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 17) : $urandom_range(0, 2);
   endfunction

   task automatic report_mismatch(input string msg);
      error_count++;
      $display("[%0t] mismatch: %s", $realtime, msg);
   endtask

   task automatic add_hsv(input int h, input int s, input int v);
      req_type px;
      px.hue_tenths = 12'(h);
      px.saturation = 10'(s);
      px.brightness = 10'(v);
      pending_hsv.push_back(px);
   endtask

   // Request driver.
   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (req_push && !req_full) begin
            expected_rgb.push_back(predict_rgb(req_data));
            if (send_calm > 0) send_calm--;
            else if ($urandom_range(0, 40) == 0) send_calm = $urandom_range(20, 80);
            send_wait = draw_wait(send_calm > 0);
         end
         if (!req_push || !req_full) begin
            if (send_wait > 0) begin
               send_wait--;
               req_push <= 1'b0;
            end else if (pending_hsv.size() > 0) begin
               req_data <= pending_hsv.pop_front();
               req_push <= 1'b1;
            end else begin
               req_push <= 1'b0;
            end
         end
      end
   end

   // Result monitor and checker.
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            rgb_checked++;
            if (expected_rgb.size() == 0) begin
               report_mismatch($sformatf("unexpected result r=%0d g=%0d b=%0d",
                  rsp_data.red_out, rsp_data.green_out, rsp_data.blue_out));
            end else begin
               rsp_type want;
               want = expected_rgb.pop_front();
               if (rsp_data.red_out !== want.red_out)
                  report_mismatch($sformatf("red got %0d want %0d",
                     rsp_data.red_out, want.red_out));
               if (rsp_data.green_out !== want.green_out)
                  report_mismatch($sformatf("green got %0d want %0d",
                     rsp_data.green_out, want.green_out));
               if (rsp_data.blue_out !== want.blue_out)
                  report_mismatch($sformatf("blue got %0d want %0d",
                     rsp_data.blue_out, want.blue_out));
            end
            if (recv_calm > 0) recv_calm--;
            else if ($urandom_range(0, 40) == 0) recv_calm = $urandom_range(20, 80);
            recv_wait = draw_wait(recv_calm > 0);
         end
         if (rsp_hold) begin
            rsp_pop <= 1'b0;
         end else if (recv_wait > 0) begin
            recv_wait--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   // Now and then the receiver stops for a long stretch so the block backs up
   // and has to push back on the request side.
   always @(posedge clock) begin
      if (reset) begin
         rsp_hold   <= 1'b0;
         hold_count <= 0;
      end else if (hold_count > 0) begin
         hold_count <= hold_count - 1;
         if (hold_count == 1) rsp_hold <= 1'b0;
      end else if (rgb_checked >= next_hold_at) begin
         rsp_hold     <= 1'b1;
         hold_count   <= HoldCycles;
         next_hold_at <= next_hold_at + 600;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WatchdogLimit) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int sel;
      int h, s, v;

      // Sector edges, full gray, black, saturation and value clamping.
      add_hsv(0, 1000, 1000);
      add_hsv(0, 0, 1000);
      add_hsv(0, 0, 0);
      add_hsv(1, 999, 999);
      add_hsv(599, 1000, 1000);
      add_hsv(600, 1000, 1000);
      add_hsv(1199, 500, 800);
      add_hsv(1200, 1000, 1000);
      add_hsv(1800, 1000, 1000);
      add_hsv(2047, 512, 512);
      add_hsv(2048, 1000, 1000);
      add_hsv(2400, 1000, 1000);
      add_hsv(3000, 1000, 1000);
      add_hsv(3599, 1000, 1000);
      add_hsv(3600, 1000, 1000);
      add_hsv(4000, 0, 0);
      add_hsv(4095, 1023, 1023);
      add_hsv(300, 1001, 1000);
      add_hsv(900, 1023, 1023);
      add_hsv(1500, 1000, 1001);
      add_hsv(2100, 750, 1023);
      add_hsv(2700, 0, 500);
      add_hsv(3300, 1, 1);

      for (int i = 0; i < RandomCount; i++) begin
         sel = $urandom_range(0, 19);
         if (sel < 16) h = $urandom_range(0, 3599);
         else if (sel < 17) h = $urandom_range(3600, 4095);
         else h = $urandom_range(0, 4095);
         sel = $urandom_range(0, 19);
         if (sel < 14) s = $urandom_range(0, 1000);
         else if (sel < 17) s = $urandom_range(1001, 1023);
         else s = $urandom_range(0, 1023);
         sel = $urandom_range(0, 19);
         if (sel < 14) v = $urandom_range(0, 1000);
         else if (sel < 17) v = $urandom_range(1001, 1023);
         else v = $urandom_range(0, 1023);
         add_hsv(h, s, v);
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (pending_hsv.size() > 0 || req_push) @(negedge clock);
      while (expected_rgb.size() > 0) @(negedge clock);
      // Leave room for any stray result to show up.
      repeat (40) @(negedge clock);

      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

[filelist.f]
hw/rtl/hsv_pkg.sv
hw/rtl/hsv_fifo.sv
hw/rtl/hsv_front.sv
hw/rtl/hsv_back.sv
hw/rtl/hsv_to_rgb_converter_core.sv
test/tb_top.sv
